/* rtl/cdf_pkg.sv */
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared constants, types and helpers of the checked frame deframer.
// ----------------------------------------------------------------------------
package cdf_pkg;

    // default depth of the payload buffer
    localparam int DEF_MAX_FRAME_BYTES = 64;

    // crc-8 generator, msb first
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // legal range of the length byte
    localparam logic [7:0] LEN_MIN = 8'd2;
    localparam logic [7:0] LEN_MAX = 8'd62;

    // frame start addresses
    localparam logic [7:0] ADDR_BROADCAST = 8'h00;
    localparam logic [7:0] ADDR_FC        = 8'hC8;
    localparam logic [7:0] ADDR_RADIO     = 8'hEA;
    localparam logic [7:0] ADDR_RX        = 8'hEC;
    localparam logic [7:0] ADDR_TX        = 8'hEE;

    // run request from the parser to the emitter
    typedef struct packed {
        logic       start;
        logic [7:0] address;
        logic [5:0] length;
        logic [7:0] ftype;
        logic [5:0] count;
    } t_emit_cmd;

    // payload buffer write port
    typedef struct packed {
        logic       we;
        logic [5:0] addr;
        logic [7:0] data;
    } t_buf_wr;

    function automatic logic known_address(input logic [7:0] b);
        known_address = (b == ADDR_BROADCAST) || (b == ADDR_FC) || (b == ADDR_RADIO) ||
                        (b == ADDR_RX) || (b == ADDR_TX);
    endfunction

endpackage

/* rtl/cdf_crc_serial.sv */
// ----------------------------------------------------------------------------
// cdf_crc_serial
// Bit-serial crc-8 unit: folds in one byte, then one polynomial step a cycle.
// ----------------------------------------------------------------------------
module cdf_crc_serial (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_start,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc,
    output logic       o_busy
);

    logic [7:0] r_crc, n_crc;
    logic [3:0] r_bits, n_bits;

    // xor in a new byte, then shift out eight bits
    always_comb begin
        n_crc  = r_crc;
        n_bits = r_bits;
        if (i_clear) begin
            n_crc  = 8'h00;
            n_bits = 4'd0;
        end else if (i_start) begin
            n_crc  = r_crc ^ i_byte;
            n_bits = 4'd8;
        end else if (r_bits != 4'd0) begin
            n_crc  = {r_crc[6:0], 1'b0} ^ (r_crc[7] ? cdf_pkg::CRC_POLY : 8'h00);
            n_bits = r_bits - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= 8'h00;
            r_bits <= 4'd0;
        end else begin
            r_crc  <= n_crc;
            r_bits <= n_bits;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = (r_bits != 4'd0);

endmodule

/* rtl/cdf_emitter.sv */
// ----------------------------------------------------------------------------
// cdf_emitter
// Payload buffer and result sequencer: plays a checked frame out beat by beat.
// ----------------------------------------------------------------------------
module cdf_emitter #(
    parameter int MAX_FRAME_BYTES = cdf_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdf_pkg::t_buf_wr   i_wr,
    input  cdf_pkg::t_emit_cmd i_cmd,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_frame_address,
    output logic [5:0]         o_frame_length,
    output logic [7:0]         o_frame_type,
    output logic [5:0]         o_payload_count,
    output logic [5:0]         o_payload_index,
    output logic [7:0]         o_payload_byte,
    output logic               o_payload_valid,
    output logic               o_last_item
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_READ = 2'd1;
    localparam logic [1:0] PH_LOAD = 2'd2;
    localparam logic [1:0] PH_HOLD = 2'd3;

    logic [7:0]  mem [MAX_FRAME_BYTES];
    logic [7:0]  r_rdata;

    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic        r_last, n_last;

    // header and beat payload registers
    logic [7:0]  r_address;
    logic [5:0]  r_length;
    logic [7:0]  r_type;
    logic [5:0]  r_count;
    logic [7:0]  r_pbyte;
    logic        r_pvalid;

    // payload buffer, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        r_rdata <= mem[AW'(r_idx)];
    end

    // sequencer: read, load the beat, hold until taken
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_last  = r_last;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.start) begin
                    n_phase = PH_READ;
                    n_idx   = 6'd0;
                end
            end
            PH_READ: begin
                n_phase = PH_LOAD;
            end
            PH_LOAD: begin
                n_valid = 1'b1;
                n_last  = (r_count == 6'd0) || (r_idx == r_count - 6'd1);
                n_phase = PH_HOLD;
            end
            PH_HOLD: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_idx   = r_idx + 6'd1;
                        n_phase = PH_READ;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= 6'd0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    // header capture and beat data
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_cmd.start) begin
            r_address <= i_cmd.address;
            r_length  <= i_cmd.length;
            r_type    <= i_cmd.ftype;
            r_count   <= i_cmd.count;
        end
        if (r_phase == PH_LOAD) begin
            r_pvalid <= (r_count != 6'd0);
            r_pbyte  <= (r_count != 6'd0) ? r_rdata : 8'h00;
        end
    end

    assign o_busy          = (r_phase != PH_IDLE);
    assign o_valid         = r_valid;
    assign o_frame_address = r_address;
    assign o_frame_length  = r_length;
    assign o_frame_type    = r_type;
    assign o_payload_count = r_count;
    assign o_payload_index = r_idx;
    assign o_payload_byte  = r_pbyte;
    assign o_payload_valid = r_pvalid;
    assign o_last_item     = r_last;

endmodule

/* rtl/crc8_checked_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// crc8_checked_frame_deframer_top
// Byte stream deframer for address/length/type/payload/crc-8 frames.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_byte_in) takes one received byte a beat.
// A frame starts on a known address byte, then a length byte of 2..62; a
// bad length drops the frame. Type and payload bytes feed a bit-serial
// crc-8 (poly 0xD5) and the payload is kept in an internal buffer.
// Address and length bytes are taken as they arrive; each type or payload
// byte is accepted, then goes through eight serial crc steps in the crc
// shift unit before the next byte is taken.
// The crc byte is compared on arrival; on a match the frame is played out on the
// output channel (o_valid/i_ready), one beat per payload byte, or one beat
// with o_payload_valid low for an empty payload. Each beat passes buffer
// read, load and present, and waits out any stall. No input is taken while a
// run is in progress; a stalled receiver simply holds the run and the
// input side. A crc mismatch drops the frame with no output.
// Reset returns the parser to waiting for an address byte; the payload
// buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module crc8_checked_frame_deframer_top #(
    parameter int MAX_FRAME_BYTES = cdf_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_address,
    output logic [5:0] o_frame_length,
    output logic [7:0] o_frame_type,
    output logic [5:0] o_payload_count,
    output logic [5:0] o_payload_index,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_last_item
);

    localparam logic [2:0] S_ADDR = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_BODY = 3'd2;
    localparam logic [2:0] S_CRC  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_address, n_address;
    logic [5:0]  r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [5:0]  r_taken, n_taken;

    logic        accept;
    logic        crc_clear, crc_start, crc_busy;
    logic [7:0]  crc_value;
    logic        emit_busy;

    cdf_pkg::t_buf_wr   buf_wr;
    cdf_pkg::t_emit_cmd emit_cmd;

    assign o_ready = (r_state == S_ADDR) || (r_state == S_LEN) || (r_state == S_BODY);
    assign accept  = i_valid && o_ready;

    // parser state machine
    always_comb begin
        n_state   = r_state;
        n_address = r_address;
        n_len     = r_len;
        n_type    = r_type;
        n_taken   = r_taken;
        crc_clear = 1'b0;
        crc_start = 1'b0;
        buf_wr    = '0;
        emit_cmd  = '0;
        unique case (r_state)
            S_ADDR: begin
                if (accept && cdf_pkg::known_address(i_byte_in)) begin
                    n_address = i_byte_in;
                    n_state   = S_LEN;
                end
            end
            S_LEN: begin
                if (accept) begin
                    if (i_byte_in >= cdf_pkg::LEN_MIN && i_byte_in <= cdf_pkg::LEN_MAX) begin
                        n_len     = i_byte_in[5:0];
                        n_taken   = 6'd0;
                        crc_clear = 1'b1;
                        n_state   = S_BODY;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_BODY: begin
                if (accept) begin
                    if (r_taken == r_len - 6'd1) begin
                        // crc byte
                        if (i_byte_in == crc_value) begin
                            emit_cmd.start   = 1'b1;
                            emit_cmd.address = r_address;
                            emit_cmd.length  = r_len;
                            emit_cmd.ftype   = r_type;
                            emit_cmd.count   = r_len - 6'd2;
                            n_state          = S_EMIT;
                        end else begin
                            n_state = S_ADDR;
                        end
                    end else begin
                        crc_start = 1'b1;
                        if (r_taken == 6'd0) begin
                            n_type = i_byte_in;
                        end else begin
                            buf_wr.we   = 1'b1;
                            buf_wr.addr = r_taken - 6'd1;
                            buf_wr.data = i_byte_in;
                        end
                        n_taken = r_taken + 6'd1;
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                if (!crc_busy) begin
                    n_state = S_BODY;
                end
            end
            S_EMIT: begin
                if (!emit_busy) begin
                    n_state = S_ADDR;
                end
            end
            default: n_state = S_ADDR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ADDR;
            r_address <= 8'h00;
            r_len     <= 6'd0;
            r_type    <= 8'h00;
            r_taken   <= 6'd0;
        end else begin
            r_state   <= n_state;
            r_address <= n_address;
            r_len     <= n_len;
            r_type    <= n_type;
            r_taken   <= n_taken;
        end
    end

    // serial crc over type and payload bytes
    cdf_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (crc_clear),
        .i_start (crc_start),
        .i_byte  (i_byte_in),
        .o_crc   (crc_value),
        .o_busy  (crc_busy)
    );

    // payload buffer and result run
    cdf_emitter #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (buf_wr),
        .i_cmd           (emit_cmd),
        .o_busy          (emit_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_address (o_frame_address),
        .o_frame_length  (o_frame_length),
        .o_frame_type    (o_frame_type),
        .o_payload_count (o_payload_count),
        .o_payload_index (o_payload_index),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_last_item     (o_last_item)
    );

    // no input beat is taken while a result beat is pending
    a_no_input_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a result beat is pending");

    // payload beats index inside the payload
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_valid) |-> (o_payload_index < o_payload_count))
        else $error("payload index beyond payload count");

    // an empty payload gives one final beat
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_payload_valid) |-> (o_last_item && o_payload_count == 6'd0))
        else $error("empty payload beat is not a single last beat");

    // the crc unit only runs while the parser waits on it
    a_crc_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_busy |-> (r_state == S_CRC))
        else $error("crc unit busy outside its wait state");

endmodule

/* tb/sv/crc8_checked_frame_deframer_top_tb.sv */
// ----------------------------------------------------------------------------
// crc8_checked_frame_deframer_top_tb
// Self-checking bench for the crc-8 checked frame deframer.
// ----------------------------------------------------------------------------
// A directed table covers the following cases:
//   - unknown start bytes
//   - length bytes below and above the legal range
//   - an empty-payload frame
//   - a crc mismatch
//   - short good frames
// Random frames follow. Most of them are well formed, one has the longest
// length, and the rest carry a bad crc, a bad length or noise bytes.
// Every accepted byte goes through a local deframer model. The beats it
// predicts are queued and compared field by field with each output beat.
// The sender runs in bursts with gaps. The receiver stalls on its own
// pattern, with one long hold-off so that the input side backs up.
// ----------------------------------------------------------------------------
module crc8_checked_frame_deframer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXB        = cdf_pkg::DEF_MAX_FRAME_BYTES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 27;
    localparam int RAND_BYTES  = 150;
    localparam int HOLD_CYCLES = 400;

    // one output beat
    typedef struct packed {
        logic [7:0] address;
        logic [5:0] length;
        logic [7:0] ftype;
        logic [5:0] count;
        logic [5:0] index;
        logic [7:0] data;
        logic       pvalid;
        logic       last;
    } t_beat;

    // how a table row turns into a byte
    typedef enum logic [2:0] {
        ROW_RAW,
        ROW_LEN,
        ROW_BODY,
        ROW_CRC_OK,
        ROW_CRC_BAD
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] value;
        logic       typed;
        t_beat      beat;
    } t_stim_row;

    typedef struct {
        logic [7:0] value;
        logic       typed;
        t_beat      beat;
    } t_plan_item;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    localparam t_beat NO_BEAT = '0;
    // address 0xC8, length 2, type 0x00, crc 0x00: one beat, no payload
    localparam t_beat EMPTY_FRAME_BEAT = '{8'hC8, 6'd2, 8'h00, 6'd0, 6'd0, 8'h00, 1'b0, 1'b1};

    localparam logic [7:0] FRAME_STARTS [5] = '{cdf_pkg::ADDR_BROADCAST, cdf_pkg::ADDR_FC,
                                                cdf_pkg::ADDR_RADIO, cdf_pkg::ADDR_RX,
                                                cdf_pkg::ADDR_TX};

    // directed stimulus
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ROW_RAW,     8'h01, 1'b0, NO_BEAT},           // unknown start byte
        '{ROW_RAW,     8'hFF, 1'b0, NO_BEAT},           // unknown start byte
        '{ROW_RAW,     8'hEE, 1'b0, NO_BEAT},
        '{ROW_RAW,     8'h01, 1'b0, NO_BEAT},           // length below range
        '{ROW_RAW,     8'hEA, 1'b0, NO_BEAT},
        '{ROW_RAW,     8'h3F, 1'b0, NO_BEAT},           // length just above range
        '{ROW_RAW,     8'hEC, 1'b0, NO_BEAT},
        '{ROW_RAW,     8'hFF, 1'b0, NO_BEAT},           // length far above range
        '{ROW_RAW,     8'hC8, 1'b0, NO_BEAT},           // empty payload frame
        '{ROW_LEN,     8'h02, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'h00, 1'b0, NO_BEAT},
        '{ROW_CRC_OK,  8'h00, 1'b1, EMPTY_FRAME_BEAT},
        '{ROW_RAW,     8'h00, 1'b0, NO_BEAT},           // crc mismatch, dropped
        '{ROW_LEN,     8'h03, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'hFF, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'h80, 1'b0, NO_BEAT},
        '{ROW_CRC_BAD, 8'h01, 1'b0, NO_BEAT},
        '{ROW_RAW,     8'hEE, 1'b0, NO_BEAT},           // two payload bytes
        '{ROW_LEN,     8'h04, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'hA5, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'h00, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'hFF, 1'b0, NO_BEAT},
        '{ROW_CRC_OK,  8'h00, 1'b0, NO_BEAT},
        '{ROW_RAW,     8'hEA, 1'b0, NO_BEAT},           // empty payload, other type
        '{ROW_LEN,     8'h02, 1'b0, NO_BEAT},
        '{ROW_BODY,    8'h5A, 1'b0, NO_BEAT},
        '{ROW_CRC_OK,  8'h00, 1'b0, NO_BEAT}
    };

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       o_ready;
    logic [7:0] i_byte_in = 8'h00;
    logic       o_valid;
    logic       i_ready   = 1'b0;
    logic [7:0] o_frame_address;
    logic [5:0] o_frame_length;
    logic [7:0] o_frame_type;
    logic [5:0] o_payload_count;
    logic [5:0] o_payload_index;
    logic [7:0] o_payload_byte;
    logic       o_payload_valid;
    logic       o_last_item;

    // model state of the deframer
    logic [6:0] mdl_taken   = '0;
    logic [5:0] mdl_length  = '0;
    logic [7:0] mdl_crc     = '0;
    logic [7:0] mdl_address = '0;
    logic [7:0] mdl_type    = '0;
    logic [7:0] mdl_payload [MAXB];

    t_beat      expected_beats [$];
    t_plan_item byte_plan [$];
    t_plan_item offered;
    t_beat      got_beat;
    t_beat      want_beat;

    int cycle_count   = 0;
    int mismatches    = 0;
    int bytes_in      = 0;
    int beats_out     = 0;
    int frames_out    = 0;
    int planned_beats = 0;
    int rx_hold_left  = 0;
    logic rx_hold_req = 1'b0;

    crc8_checked_frame_deframer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_byte_in       (i_byte_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_address (o_frame_address),
        .o_frame_length  (o_frame_length),
        .o_frame_type    (o_frame_type),
        .o_payload_count (o_payload_count),
        .o_payload_index (o_payload_index),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_last_item     (o_last_item)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // crc-8 poly 0xD5, msb first, one byte
    function automatic logic [7:0] crc_d5_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ cdf_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // advance the model by one accepted byte and queue the beats it yields
    task automatic deframe_byte(input logic [7:0] b, input logic typed, input t_beat typed_beat);
        t_beat      run_beats [$];
        t_beat      r;
        logic [5:0] n;
        if (mdl_taken == 0) begin
            if (cdf_pkg::known_address(b)) begin
                mdl_address = b;
                mdl_taken   = 7'd1;
            end
        end else if (mdl_taken == 1) begin
            if (b < cdf_pkg::LEN_MIN || b > cdf_pkg::LEN_MAX) begin
                mdl_taken  = '0;
                mdl_length = '0;
            end else begin
                mdl_length = b[5:0];
                mdl_crc    = '0;
                mdl_taken  = 7'd2;
            end
        end else if (int'(mdl_taken) + 1 >= int'(mdl_length) + 2) begin
            // crc byte closes the frame
            if (b == mdl_crc) begin
                n = mdl_length - 6'd2;
                if (n == 0) begin
                    r = '{mdl_address, mdl_length, mdl_type, 6'd0, 6'd0, 8'h00, 1'b0, 1'b1};
                    run_beats.push_back(r);
                end else begin
                    for (int i = 0; i < int'(n); i++) begin
                        r = '{mdl_address, mdl_length, mdl_type, n, 6'(i), mdl_payload[i],
                              1'b1, (i + 1 == int'(n))};
                        run_beats.push_back(r);
                    end
                end
                if (typed) begin
                    expected_beats.push_back(typed_beat);
                end else begin
                    foreach (run_beats[i]) expected_beats.push_back(run_beats[i]);
                end
            end
            mdl_taken  = '0;
            mdl_length = '0;
        end else begin
            // type or payload byte
            mdl_crc = crc_d5_step(mdl_crc, b);
            if (mdl_taken == 2) begin
                mdl_type = b;
            end else if (int'(mdl_taken) - 3 < MAXB) begin
                mdl_payload[int'(mdl_taken) - 3] = b;
            end
            mdl_taken = mdl_taken + 7'd1;
            if (int'(mdl_taken) >= MAXB) begin
                mdl_taken  = '0;
                mdl_length = '0;
            end
        end
    endtask

    // input and output beats, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            bytes_in++;
            deframe_byte(i_byte_in, offered.typed, offered.beat);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got_beat = '{o_frame_address, o_frame_length, o_frame_type, o_payload_count,
                         o_payload_index, o_payload_byte, o_payload_valid, o_last_item};
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: beat with nothing expected: %p", $realtime, got_beat);
            end else begin
                want_beat = expected_beats.pop_front();
                if (got_beat !== want_beat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: beat mismatch", $realtime);
                        $display("  expected %p", want_beat);
                        $display("  actual   %p", got_beat);
                    end
                end
                beats_out++;
                if (got_beat.last) frames_out++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     expected_beats.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: stall patterns, plus a long hold-off on request
    initial begin
        t_rx_mode mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_RANDOM: i_ready <= ($urandom_range(0, 2) != 0);
                    default:   i_ready <= left[2];
                endcase
            end
        end
    end

    task automatic plan_byte(input logic [7:0] v);
        byte_plan.push_back('{v, 1'b0, NO_BEAT});
    endtask

    // one whole frame with random type and payload
    task automatic plan_frame(input logic [5:0] len, input logic good);
        logic [7:0] crc;
        logic [7:0] v;
        crc = 8'h00;
        plan_byte(FRAME_STARTS[$urandom_range(0, 4)]);
        plan_byte({2'b00, len});
        for (int i = 0; i < int'(len) - 1; i++) begin
            v   = 8'($urandom_range(0, 255));
            crc = crc_d5_step(crc, v);
            plan_byte(v);
        end
        plan_byte(good ? crc : crc ^ 8'($urandom_range(1, 255)));
        if (good) planned_beats += (len == 2) ? 1 : int'(len) - 2;
    endtask

    // sender: bursts of beats with random gaps
    task automatic offer_plan();
        t_plan_item it;
        int         burst_left;
        int         gap;
        burst_left = 0;
        while (byte_plan.size() > 0) begin
            it = byte_plan.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    @(negedge i_clk) i_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            @(negedge i_clk);
            offered = it;
            i_valid   <= 1'b1;
            i_byte_in <= it.value;
            do @(posedge i_clk); while (!o_ready);
            burst_left--;
        end
        @(negedge i_clk) i_valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        logic [7:0] walk_crc;
        logic [7:0] v;
        logic       long_done;
        int         pick;
        int         len;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        walk_crc = 8'h00;
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_LEN: begin
                    walk_crc = 8'h00;
                    v = directed_rows[i].value;
                end
                ROW_BODY: begin
                    walk_crc = crc_d5_step(walk_crc, directed_rows[i].value);
                    v = directed_rows[i].value;
                end
                ROW_CRC_OK:  v = walk_crc;
                ROW_CRC_BAD: v = walk_crc ^ directed_rows[i].value;
                default:     v = directed_rows[i].value;
            endcase
            byte_plan.push_back('{v, directed_rows[i].typed, directed_rows[i].beat});
        end
        offer_plan();

        // sender pause until everything has drained
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        // random frames, mostly well formed
        long_done = 1'b0;
        while (byte_plan.size() < RAND_BYTES || !long_done || planned_beats < 48) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if (!long_done && byte_plan.size() >= 60) begin
                    len = cdf_pkg::LEN_MAX;
                    long_done = 1'b1;
                end else if ($urandom_range(0, 24) == 0) begin
                    len = $urandom_range(cdf_pkg::LEN_MIN, cdf_pkg::LEN_MAX);
                end else begin
                    len = $urandom_range(cdf_pkg::LEN_MIN, 8);
                end
                plan_frame(6'(len), 1'b1);
            end else if (pick < 80) begin
                plan_frame(6'($urandom_range(cdf_pkg::LEN_MIN, 10)), 1'b0);
            end else if (pick < 90) begin
                // start byte then a length out of range
                plan_byte(FRAME_STARTS[$urandom_range(0, 4)]);
                if ($urandom_range(0, 1) == 0)
                    plan_byte(8'($urandom_range(0, 1)));
                else
                    plan_byte(8'($urandom_range(63, 255)));
            end else begin
                // noise outside frames, never a start byte
                repeat ($urandom_range(1, 3)) begin
                    v = 8'($urandom_range(0, 255));
                    if (cdf_pkg::known_address(v))
                        v = v ^ 8'h01;
                    plan_byte(v);
                end
            end
        end

        // long receiver hold-off while the sender keeps offering
        rx_hold_req = 1'b1;
        offer_plan();

        // drain
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d bytes in, %0d beats out over %0d frames, %0d mismatches",
                 bytes_in, beats_out, frames_out, mismatches);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cdf_pkg.sv
rtl/cdf_crc_serial.sv
rtl/cdf_emitter.sv
rtl/crc8_checked_frame_deframer_top.sv
tb/sv/crc8_checked_frame_deframer_top_tb.sv
